/* src/tgs_pkg.sv */
// tgs_pkg: shared types, codes and helpers for the trilinear grid sampler
// no dependencies; used by tgs_ctrl, tgs_datapath and trilinear_grid_sampler
`default_nettype none
package tgs_pkg;

	localparam int FUNC_W = 3;
	localparam int CELL_W = 5;
	localparam int PT_W = 18;
	localparam int COMP_W = 2;
	localparam int VAL_W = 32;
	localparam int GS_W = 6;
	localparam int C_W = VAL_W + 2;
	localparam int ACC_W = C_W + 3;
	localparam int FOLD_CW = $clog2(PT_W);
	localparam int IN_W = 3 * CELL_W + 3 * PT_W + COMP_W + VAL_W;
	localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;

	localparam logic [FUNC_W-1:0] FN_WRITE     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_READ      = 3'd1;
	localparam logic [FUNC_W-1:0] FN_SAMPLE    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SPLAT_SET = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SPLAT_ADD = 3'd4;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [COMP_W-1:0]       component;
		logic signed [PT_W-1:0]  point_z;
		logic signed [PT_W-1:0]  point_y;
		logic signed [PT_W-1:0]  point_x;
		logic [CELL_W-1:0]       cell_z;
		logic [CELL_W-1:0]       cell_y;
		logic [CELL_W-1:0]       cell_x;
	} in_item_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_CELL,
		KIND_CORNER
	} op_kind_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic fold_step;
		logic fold_fin;
		logic cell_op;
		logic rd_issue;
		logic wt_stage;
		logic mul_stage;
		logic acc_stage;
		logic corner_next;
		logic emit;
	} tgs_cmd_t;

	typedef struct packed {
		op_kind_t kind;
		logic     periodic;
		logic     corner_skip;
		logic     corner_last;
	} tgs_sts_t;

	function automatic logic [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sd2147483647);
		lo = -ACC_W'(64'sd2147483648);
		if (v > hi) begin
			return 32'h7fff_ffff;
		end else if (v < lo) begin
			return 32'h8000_0000;
		end
		return v[VAL_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* src/tgs_ctrl.sv */
// tgs_ctrl: sequencer for cell access, point folding and the eight-corner loop
// depends on tgs_pkg
`default_nettype none
module tgs_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_valid,
	output logic                  s_ready,
	output logic                  m_valid,
	input  wire logic             m_ready,
	input  wire tgs_pkg::tgs_sts_t sts,
	output tgs_pkg::tgs_cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FOLD, S_FOLD_END, S_CELL, S_CELL_WAIT,
		S_C_RD, S_C_WT, S_C_MUL, S_C_ACC, S_OUT
	} state_t;

	state_t state_q;
	logic [tgs_pkg::FOLD_CW-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign s_ready = (state_q == S_IDLE);
	assign m_valid = out_valid_q;
	assign out_free = !out_valid_q || m_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = s_valid;
			S_DECODE: cmd.prep = 1'b1;
			S_FOLD: cmd.fold_step = 1'b1;
			S_FOLD_END: cmd.fold_fin = 1'b1;
			S_CELL: cmd.cell_op = 1'b1;
			S_C_RD: begin
				cmd.rd_issue = !sts.corner_skip;
				cmd.corner_next = sts.corner_skip;
			end
			S_C_WT: cmd.wt_stage = 1'b1;
			S_C_MUL: cmd.mul_stage = 1'b1;
			S_C_ACC: begin
				cmd.acc_stage = 1'b1;
				cmd.corner_next = 1'b1;
			end
			S_OUT: cmd.emit = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					cnt_q <= tgs_pkg::FOLD_CW'(tgs_pkg::PT_W - 1);
					case (sts.kind)
						tgs_pkg::KIND_CELL: state_q <= S_CELL;
						tgs_pkg::KIND_CORNER: state_q <= sts.periodic ? S_FOLD : S_C_RD;
						default: state_q <= S_OUT;
					endcase
				end
				S_FOLD: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= S_FOLD_END;
				end
				S_FOLD_END: state_q <= S_C_RD;
				S_CELL: state_q <= S_CELL_WAIT;
				S_CELL_WAIT: state_q <= S_OUT;
				S_C_RD: begin
					if (!sts.corner_skip) begin
						state_q <= S_C_WT;
					end else if (sts.corner_last) begin
						state_q <= S_OUT;
					end
				end
				S_C_WT: state_q <= S_C_MUL;
				S_C_MUL: state_q <= S_C_ACC;
				S_C_ACC: state_q <= sts.corner_last ? S_OUT : S_C_RD;
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/tgs_datapath.sv */
// tgs_datapath: grid memory, point folding, corner weights, products and result register
// depends on tgs_pkg
`default_nettype none
module tgs_datapath #(
	parameter int MAX_CELLS_PER_AXIS = 32,
	parameter int COMPONENTS = 3,
	parameter int FRAC_BITS = 10
) (
	input  wire logic                        clk,
	input  wire tgs_pkg::tgs_cmd_t           cmd,
	output tgs_pkg::tgs_sts_t                sts,
	input  wire logic [tgs_pkg::FUNC_W-1:0]  in_func,
	input  wire tgs_pkg::in_item_t           in_item,
	input  wire logic                        mode,
	input  wire logic [tgs_pkg::GS_W-1:0]    grid_size,
	output logic [tgs_pkg::VAL_W-1:0]        out_value,
	output logic                             out_status
);

	localparam int F = FRAC_BITS;
	localparam int AW = $clog2(MAX_CELLS_PER_AXIS);
	localparam int NW = $clog2(MAX_CELLS_PER_AXIS + 1);
	localparam int IW = AW + 2;
	localparam int TOP_W = AW + F;
	localparam int CMP_W = ((tgs_pkg::PT_W > TOP_W) ? tgs_pkg::PT_W : TOP_W) + 2;
	localparam int REM_W = TOP_W + 1;
	localparam int W_W = F + 1;
	localparam int WP1_W = 2 * W_W;
	localparam int WP2_W = 3 * W_W;
	localparam int PROD_W = tgs_pkg::VAL_W + W_W + 1;
	localparam int MEM_DEPTH = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS
		* COMPONENTS;
	localparam int MEM_AW = $clog2(MEM_DEPTH);

	typedef enum logic [1:0] {FC_KEEP, FC_NEG, FC_OVER} fold_case_t;

	// captured item
	logic [tgs_pkg::FUNC_W-1:0] func_q;
	tgs_pkg::in_item_t item_q;
	logic mode_q;
	logic [NW-1:0] n_q;

	// folding
	logic [TOP_W-1:0] pf_q [3];
	logic [REM_W-1:0] rem_q [3];
	logic [tgs_pkg::PT_W-1:0] div_q [3];
	fold_case_t fcase_q [3];

	// corner loop
	logic [2:0] corner_q;
	logic [WP1_W-1:0] wp1_q;
	logic [WP2_W-1:0] wp2_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [tgs_pkg::ACC_W-1:0] acc_q;
	logic [tgs_pkg::VAL_W-1:0] mem_q;
	logic [tgs_pkg::VAL_W-1:0] grid_mem [MEM_DEPTH];

	logic [7:0] gs8;
	logic [7:0] n8;
	logic [TOP_W-1:0] top;
	logic signed [tgs_pkg::PT_W-1:0] pt [3];
	logic [TOP_W-1:0] clamp_v [3];
	fold_case_t start_case [3];
	logic [tgs_pkg::PT_W-1:0] start_div [3];
	logic [REM_W-1:0] rem_next [3];
	logic [TOP_W-1:0] fin_v [3];
	logic [AW:0] coord [3];
	logic [W_W-1:0] wsel [3];
	logic [2:0] dsel;
	logic skip;
	logic comp_bad;
	logic cell_oob;
	logic ignored;
	tgs_pkg::op_kind_t kind;
	logic [MEM_AW-1:0] cell_addr;
	logic [MEM_AW-1:0] corner_addr;
	logic [MEM_AW-1:0] addr;
	logic mem_we;
	logic mem_re;
	logic [tgs_pkg::VAL_W-1:0] mem_wdata;
	logic [WP2_W-1:0] wsum;
	logic [W_W-1:0] wr;
	logic signed [tgs_pkg::VAL_W-1:0] operand;
	logic signed [PROD_W-1:0] prnd;
	logic signed [PROD_W-1:0] pshift;
	logic signed [tgs_pkg::C_W-1:0] cval;
	logic signed [tgs_pkg::ACC_W-1:0] cext;
	logic signed [tgs_pkg::ACC_W-1:0] msum;

	function automatic logic [MEM_AW-1:0] addr_of(input logic [AW-1:0] x,
		input logic [AW-1:0] y, input logic [AW-1:0] z,
		input logic [tgs_pkg::COMP_W-1:0] c);
		logic [MEM_AW-1:0] m;
		m = MEM_AW'(MAX_CELLS_PER_AXIS);
		return ((MEM_AW'(z) * m + MEM_AW'(y)) * m + MEM_AW'(x)) * MEM_AW'(COMPONENTS)
			+ MEM_AW'(c);
	endfunction

	// effective grid size, saturated into [2, MAX]
	assign gs8 = {2'b00, grid_size};
	always_comb begin
		if (gs8 < 8'd2) begin
			n8 = 8'd2;
		end else if (gs8 > 8'(MAX_CELLS_PER_AXIS)) begin
			n8 = 8'(MAX_CELLS_PER_AXIS);
		end else begin
			n8 = gs8;
		end
	end

	assign top = TOP_W'(n_q - 1'b1) << F;
	assign pt[0] = item_q.point_x;
	assign pt[1] = item_q.point_y;
	assign pt[2] = item_q.point_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [CMP_W-1:0] ps;
			logic signed [CMP_W-1:0] tc;
			logic [REM_W-1:0] r2;
			ps = CMP_W'(pt[i]);
			tc = $signed({{(CMP_W - TOP_W){1'b0}}, top});
			if (pt[i] < 0) begin
				clamp_v[i] = '0;
				start_case[i] = FC_NEG;
				start_div[i] = tgs_pkg::PT_W'(-ps);
			end else if (ps > tc) begin
				clamp_v[i] = top;
				start_case[i] = FC_OVER;
				start_div[i] = tgs_pkg::PT_W'(ps - CMP_W'(1));
			end else begin
				clamp_v[i] = TOP_W'(ps);
				start_case[i] = FC_KEEP;
				start_div[i] = '0;
			end
			// one restoring remainder step
			r2 = {rem_q[i][REM_W-2:0], div_q[i][tgs_pkg::PT_W-1]};
			if (r2 >= {1'b0, top}) begin
				rem_next[i] = r2 - {1'b0, top};
			end else begin
				rem_next[i] = r2;
			end
			case (fcase_q[i])
				FC_NEG: fin_v[i] = (rem_q[i] == '0) ? '0 : top - rem_q[i][TOP_W-1:0];
				FC_OVER: fin_v[i] = rem_q[i][TOP_W-1:0] + 1'b1;
				default: fin_v[i] = pf_q[i];
			endcase
		end
	end

	// corner coordinates and per-axis weights (opposite corner)
	assign dsel = {corner_q[0], corner_q[1], corner_q[2]};
	always_comb begin
		skip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			logic [F-1:0] fr;
			fr = pf_q[i][F-1:0];
			coord[i] = {1'b0, pf_q[i][TOP_W-1:F]} + (AW + 1)'(dsel[i]);
			wsel[i] = dsel[i] ? {1'b0, fr} : W_W'(1 << F) - {1'b0, fr};
			if (IW'(coord[i]) >= IW'(n_q)) skip = 1'b1;
		end
	end

	// decode
	always_comb begin
		comp_bad = {2'b00, item_q.component} >= 4'(COMPONENTS);
		cell_oob = (8'(item_q.cell_x) >= 8'(n_q)) || (8'(item_q.cell_y) >= 8'(n_q))
			|| (8'(item_q.cell_z) >= 8'(n_q));
		kind = tgs_pkg::KIND_NONE;
		ignored = 1'b0;
		case (func_q)
			tgs_pkg::FN_WRITE, tgs_pkg::FN_READ: begin
				ignored = comp_bad || cell_oob;
				kind = ignored ? tgs_pkg::KIND_NONE : tgs_pkg::KIND_CELL;
			end
			tgs_pkg::FN_SAMPLE, tgs_pkg::FN_SPLAT_SET, tgs_pkg::FN_SPLAT_ADD: begin
				ignored = comp_bad;
				kind = ignored ? tgs_pkg::KIND_NONE : tgs_pkg::KIND_CORNER;
			end
			default: begin
				kind = tgs_pkg::KIND_NONE;
				ignored = 1'b0;
			end
		endcase
	end

	assign sts.kind = kind;
	assign sts.periodic = mode_q;
	assign sts.corner_skip = skip;
	assign sts.corner_last = (corner_q == 3'd7);

	// weight rounding and contribution rounding
	assign wsum = wp2_q + (WP2_W'(1) << (2 * F - 1));
	assign wr = W_W'(wsum >> (2 * F));
	assign operand = (func_q == tgs_pkg::FN_SAMPLE) ? $signed(mem_q) : item_q.value;
	assign prnd = prod_q + (PROD_W'(1) << (F - 1));
	assign pshift = prnd >>> F;
	assign cval = pshift[tgs_pkg::C_W-1:0];
	assign cext = tgs_pkg::ACC_W'(cval);
	assign msum = tgs_pkg::ACC_W'($signed(mem_q)) + cext;

	// memory port
	assign cell_addr = addr_of(AW'(item_q.cell_x), AW'(item_q.cell_y), AW'(item_q.cell_z),
		item_q.component);
	assign corner_addr = addr_of(coord[0][AW-1:0], coord[1][AW-1:0], coord[2][AW-1:0],
		item_q.component);
	assign addr = cmd.cell_op ? cell_addr : corner_addr;
	assign mem_we = (cmd.cell_op && func_q == tgs_pkg::FN_WRITE)
		|| (cmd.acc_stage && func_q != tgs_pkg::FN_SAMPLE);
	assign mem_re = (cmd.cell_op && func_q == tgs_pkg::FN_READ) || cmd.rd_issue;
	always_comb begin
		if (cmd.cell_op) begin
			mem_wdata = item_q.value;
		end else if (func_q == tgs_pkg::FN_SPLAT_SET) begin
			mem_wdata = tgs_pkg::sat32(cext);
		end else begin
			mem_wdata = tgs_pkg::sat32(msum);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) grid_mem[addr] <= mem_wdata;
		if (mem_re) mem_q <= grid_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			item_q <= in_item;
			mode_q <= mode;
			n_q <= NW'(n8);
		end
		if (cmd.prep) begin
			corner_q <= '0;
			acc_q <= '0;
			for (int i = 0; i < 3; i++) begin
				pf_q[i] <= mode_q ? clamp_v[i] : clamp_v[i];
				fcase_q[i] <= mode_q ? start_case[i] : FC_KEEP;
				div_q[i] <= start_div[i];
				rem_q[i] <= '0;
			end
		end
		if (cmd.fold_step) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= rem_next[i];
				div_q[i] <= div_q[i] << 1;
			end
		end
		if (cmd.fold_fin) begin
			for (int i = 0; i < 3; i++) pf_q[i] <= fin_v[i];
		end
		if (cmd.rd_issue) wp1_q <= wsel[0] * wsel[1];
		if (cmd.wt_stage) wp2_q <= wp1_q * WP2_W'(wsel[2]);
		if (cmd.mul_stage) prod_q <= operand * $signed({1'b0, wr});
		if (cmd.acc_stage) acc_q <= acc_q + cext;
		if (cmd.corner_next) corner_q <= corner_q + 1'b1;
		if (cmd.emit) begin
			out_status <= ignored;
			if (kind == tgs_pkg::KIND_CELL && func_q == tgs_pkg::FN_READ) begin
				out_value <= mem_q;
			end else if (kind == tgs_pkg::KIND_CORNER && func_q == tgs_pkg::FN_SAMPLE) begin
				out_value <= tgs_pkg::sat32(acc_q);
			end else begin
				out_value <= '0;
			end
		end
	end

endmodule
`default_nettype wire

/* src/trilinear_grid_sampler.sv */
// sequence: a cell read or write makes one memory access, an ignored item goes straight to the result,
// sample and splat walk the eight corners and skip any corner outside the grid,
// and in periodic mode each coordinate is first folded with a bit-serial remainder
// throughput: one item at a time, set by the single-port grid memory and shared multipliers
// reset: registers return to clamp mode and grid size 32; grid memory holds garbage until written
// depends on tgs_pkg, tgs_ctrl, tgs_datapath
`default_nettype none
module trilinear_grid_sampler #(
	parameter int MAX_CELLS_PER_AXIS = 32,
	parameter int COMPONENTS = 3,
	parameter int FRAC_BITS = 10
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input item stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// cell_x, cell_y, cell_z, point_x, point_y, point_z, component, value, zero pad
	input  wire logic [tgs_pkg::IN_DATA_W-1:0]   s_tdata,
	// func
	input  wire logic [tgs_pkg::FUNC_W-1:0]      s_tuser,
	// result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// result_value
	output logic [tgs_pkg::VAL_W-1:0]            m_tdata,
	// status
	output logic                                 m_tuser,
	// register port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [2:0]                      paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	logic mode_q;
	logic [tgs_pkg::GS_W-1:0] gsize_q;
	tgs_pkg::tgs_cmd_t cmd;
	tgs_pkg::tgs_sts_t sts;
	tgs_pkg::in_item_t item;

	// register file: boundary mode at 0, grid size at 4
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			gsize_q <= tgs_pkg::GS_W'(32);
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == tgs_pkg::REG_SIZE) begin
				gsize_q <= pwdata[tgs_pkg::GS_W-1:0];
			end else begin
				mode_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			tgs_pkg::REG_MODE: prdata = {31'd0, mode_q};
			tgs_pkg::REG_SIZE: prdata = {26'd0, gsize_q};
			default: prdata = '0;
		endcase
	end

	// unpack the payload, first field in the low bits
	assign item = tgs_pkg::in_item_t'(s_tdata[tgs_pkg::IN_W-1:0]);

	tgs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tgs_datapath #(
		.MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
		.COMPONENTS         (COMPONENTS),
		.FRAC_BITS          (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.sts        (sts),
		.in_func    (s_tuser),
		.in_item    (item),
		.mode       (mode_q),
		.grid_size  (gsize_q),
		.out_value  (m_tdata),
		.out_status (m_tuser)
	);

	// one item in flight: the input closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// an ignored access never carries data
	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("ignored access returned nonzero data");

endmodule
`default_nettype wire
